// ===== rtl/dfd_pkg.sv =====
package dfd_pkg;

  // Fixed field widths
  localparam int DATA_W    = 8;
  localparam int SIZE_W    = 32;
  localparam int KIND_W    = 3;
  localparam int VALUE_W   = 64;
  localparam int INDEX_W   = 20;
  localparam int ERR_W     = 2;
  localparam int IMG_W     = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 10;
  localparam int FNUM_W    = 32;
  localparam int BIF_W     = 3;

  // Default image limits
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEPTH_PRESENT = 3'd0,
    REG_IMAGE_WIDTH   = 3'd1,
    REG_IMAGE_HEIGHT  = 3'd2,
    REG_DIST_PRESENT  = 3'd3,
    REG_INT_PRESENT   = 3'd4,
    REG_CONF_PRESENT  = 3'd5
  } dfd_reg_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_TS   = 3'd0,
    KIND_FNUM = 3'd1,
    KIND_DIST = 3'd2,
    KIND_INT  = 3'd3,
    KIND_CONF = 3'd4,
    KIND_OK   = 3'd5,
    KIND_ERR  = 3'd6
  } dfd_kind_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE     = 2'd0,
    ERR_LEN_SIZE = 2'd1,
    ERR_LEN_COPY = 2'd2
  } dfd_err_t;

  typedef struct packed {
    dfd_kind_t           kind;
    logic [VALUE_W-1:0]  value;
    logic [INDEX_W-1:0]  index;
    dfd_err_t            err;
  } dfd_result_t;

endpackage

// ===== rtl/dfd_if.sv =====
interface dfd_in_if;
  import dfd_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic [SIZE_W-1:0] package_size;

  modport source (output valid, output data_byte, output package_size, input ready);
  modport sink   (input valid, input data_byte, input package_size, output ready);
endinterface

interface dfd_out_if;
  import dfd_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  item_kind;
  logic [VALUE_W-1:0] item_value;
  logic [INDEX_W-1:0] pixel_index;
  logic [ERR_W-1:0]   error_code;

  modport source (output valid, output item_kind, output item_value, output pixel_index,
                  output error_code, input ready);
  modport sink   (input valid, input item_kind, input item_value, input pixel_index,
                  input error_code, output ready);
endinterface

// ===== rtl/depth_frame_deframer.sv =====
// Depth frame deframer.
// in_bus (sink): one byte of the binary data set per beat, with the package
//   size, which is sampled on the first length byte of every frame.
// out_bus (source): timestamp, frame number, distance / intensity /
//   confidence pixels with their index, frame ok, or an error beat.
// cfg_we / cfg_index / cfg_data: write-only register port, one register per
//   write; write only while the block is idle.
// Throughput: one byte per cycle while in_bus.ready is high. A result is
//   registered from the last byte of its field; most bytes give no beat.
// The state machine updates on the accepting edge; results go through a
//   two-entry output buffer, so a byte is still taken while one result
//   waits. in_bus.ready drops only when both entries are full.
// While depth_map_present is zero, bytes are taken and dropped and the
//   frame position holds.
// Reset (rst_n low, synchronous) clears all registers to zero, the frame
//   counter too, and returns the parser to wait for a length field.
// The pixel total (clamped width times height) is registered from the
//   values being written, so it is current from the edge of the write on.
module depth_frame_deframer #(
  parameter int MAX_WIDTH  = dfd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = dfd_pkg::MAX_HEIGHT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  dfd_in_if.sink                     in_bus,
  dfd_out_if.source                  out_bus,
  input  logic                       cfg_we,
  input  logic [dfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dfd_pkg::CFG_DAT_W-1:0] cfg_data
);
  import dfd_pkg::*;

  // Clamp and pixel-count widths follow the image limits
  localparam int WC_W   = $clog2(MAX_WIDTH + 1);
  localparam int HC_W   = $clog2(MAX_HEIGHT + 1);
  localparam int WX     = (WC_W > IMG_W) ? WC_W : IMG_W;
  localparam int HX     = (HC_W > IMG_W) ? HC_W : IMG_W;
  localparam int PROD_W = WX + HX;
  localparam int PIX_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

  typedef enum logic [3:0] {
    PH_LEN, PH_TS, PH_VER, PH_FNUM, PH_SKIP,
    PH_DIST, PH_INT, PH_CONF, PH_CRC, PH_LCOPY
  } phase_t;

  // Configuration
  logic             dmap_r, dist_r, int_r, conf_r;
  logic [IMG_W-1:0] width_r, height_r;
  logic [IMG_W-1:0] width_nxt, height_nxt;

  // Parser state
  phase_t             phase_r, phase_nxt;
  logic [BIF_W-1:0]   bif_r, bif_nxt;
  logic [PIX_W-1:0]   pix_cnt_r, pix_cnt_nxt;
  logic [VALUE_W-1:0] acc_r, acc_nxt;
  logic [SIZE_W-1:0]  hdr_len_r, hdr_len_nxt;
  logic [SIZE_W-1:0]  size_r, size_nxt;
  logic [FNUM_W-1:0]  fnum_r, fnum_nxt;
  logic [PIX_W-1:0]   total_r;

  // Pixel total, taken from the values after this cycle's register write
  logic [WX-1:0]     w_ext, w_clamp;
  logic [HX-1:0]     h_ext, h_clamp;
  logic [PROD_W-1:0] prod;

  assign width_nxt  = (cfg_we && cfg_index == REG_IMAGE_WIDTH)  ? cfg_data[IMG_W-1:0] : width_r;
  assign height_nxt = (cfg_we && cfg_index == REG_IMAGE_HEIGHT) ? cfg_data[IMG_W-1:0] : height_r;

  assign w_ext   = WX'(width_nxt);
  assign h_ext   = HX'(height_nxt);
  assign w_clamp = (w_ext > WX'(MAX_WIDTH))  ? WX'(MAX_WIDTH)  : w_ext;
  assign h_clamp = (h_ext > HX'(MAX_HEIGHT)) ? HX'(MAX_HEIGHT) : h_ext;
  assign prod    = PROD_W'(w_clamp) * PROD_W'(h_clamp);

  // Next map phase, starting at distance, intensity or confidence
  phase_t nm_dist, nm_int, nm_conf;
  logic   tot_zero;

  assign tot_zero = (total_r == '0);

  always_comb begin
    nm_conf = (!tot_zero && conf_r) ? PH_CONF : PH_CRC;
    nm_int  = (!tot_zero && int_r)  ? PH_INT  : nm_conf;
    nm_dist = (!tot_zero && dist_r) ? PH_DIST : nm_int;
  end

  // Byte handling
  logic               in_acc;
  logic               res_vld;
  dfd_result_t        res;
  logic               res_ready;
  logic [BIF_W:0]     bif_inc;
  logic [BIF_W:0]     fbytes;
  logic [VALUE_W-1:0] merged;
  logic [PIX_W:0]     cnt_inc;
  logic [FNUM_W-1:0]  fnum_inc;
  dfd_kind_t          map_kind;

  assign in_bus.ready = res_ready;
  assign in_acc       = in_bus.valid && res_ready;
  assign bif_inc      = {1'b0, bif_r} + 1'b1;
  assign merged       = acc_r | (VALUE_W'(in_bus.data_byte) << {bif_r, 3'b000});
  assign cnt_inc      = {1'b0, pix_cnt_r} + 1'b1;
  assign fnum_inc     = fnum_r + 1'b1;   // wraps at 32 bits

  always_comb begin
    case (phase_r)
      PH_TS:                                    fbytes = 4'd8;
      PH_VER, PH_SKIP, PH_DIST, PH_INT, PH_CONF: fbytes = 4'd2;
      default:                                  fbytes = 4'd4;
    endcase
  end

  always_comb begin
    case (phase_r)
      PH_INT:  map_kind = KIND_INT;
      PH_CONF: map_kind = KIND_CONF;
      default: map_kind = KIND_DIST;
    endcase
  end

  always_comb begin
    phase_nxt   = phase_r;
    bif_nxt     = bif_r;
    pix_cnt_nxt = pix_cnt_r;
    acc_nxt     = acc_r;
    hdr_len_nxt = hdr_len_r;
    size_nxt    = size_r;
    fnum_nxt    = fnum_r;
    res_vld     = 1'b0;
    res         = '{kind: KIND_TS, value: '0, index: '0, err: ERR_NONE};

    if (in_acc && dmap_r) begin
      if (phase_r == PH_LEN && bif_r == '0) size_nxt = in_bus.package_size;

      if (bif_inc < fbytes) begin
        acc_nxt = merged;
        bif_nxt = bif_inc[BIF_W-1:0];
      end else begin
        acc_nxt = '0;
        bif_nxt = '0;
        unique case (phase_r)
          PH_LEN: begin
            hdr_len_nxt = merged[SIZE_W-1:0];
            if (merged[SIZE_W-1:0] > size_r) begin
              phase_nxt = PH_LEN;
              res_vld   = 1'b1;
              res.kind  = KIND_ERR;
              res.value = VALUE_W'(merged[SIZE_W-1:0]);
              res.err   = ERR_LEN_SIZE;
            end else begin
              phase_nxt = PH_TS;
            end
          end
          PH_TS: begin
            phase_nxt = PH_VER;
            res_vld   = 1'b1;
            res.kind  = KIND_TS;
            res.value = merged;
          end
          PH_VER: begin
            if (merged[15:0] > 16'd1) begin
              phase_nxt = PH_FNUM;
            end else begin
              // old format: frame counter kept here
              fnum_nxt    = fnum_inc;
              pix_cnt_nxt = '0;
              phase_nxt   = nm_dist;
              res_vld     = 1'b1;
              res.kind    = KIND_FNUM;
              res.value   = VALUE_W'(fnum_inc);
            end
          end
          PH_FNUM: begin
            fnum_nxt  = merged[FNUM_W-1:0];
            phase_nxt = PH_SKIP;
            res_vld   = 1'b1;
            res.kind  = KIND_FNUM;
            res.value = VALUE_W'(merged[FNUM_W-1:0]);
          end
          PH_SKIP: begin
            pix_cnt_nxt = '0;
            phase_nxt   = nm_dist;
          end
          PH_DIST, PH_INT, PH_CONF: begin
            res_vld   = 1'b1;
            res.kind  = map_kind;
            res.value = VALUE_W'(merged[15:0]);
            res.index = INDEX_W'(pix_cnt_r);
            if (cnt_inc >= {1'b0, total_r}) begin
              // map done: move to the next one present
              pix_cnt_nxt = '0;
              case (phase_r)
                PH_DIST: phase_nxt = nm_int;
                PH_INT:  phase_nxt = nm_conf;
                default: phase_nxt = PH_CRC;
              endcase
            end else begin
              pix_cnt_nxt = cnt_inc[PIX_W-1:0];
            end
          end
          PH_CRC: begin
            phase_nxt = PH_LCOPY;
          end
          PH_LCOPY: begin
            phase_nxt = PH_LEN;
            res_vld   = 1'b1;
            if (merged[SIZE_W-1:0] != hdr_len_r) begin
              res.kind  = KIND_ERR;
              res.value = VALUE_W'(merged[SIZE_W-1:0]);
              res.err   = ERR_LEN_COPY;
            end else begin
              res.kind  = KIND_OK;
              res.value = VALUE_W'(fnum_r);
            end
          end
          default: phase_nxt = PH_LEN;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_LEN;
      bif_r     <= '0;
      pix_cnt_r <= '0;
      acc_r     <= '0;
      hdr_len_r <= '0;
      size_r    <= '0;
      fnum_r    <= '0;
      total_r   <= '0;
      dmap_r    <= 1'b0;
      dist_r    <= 1'b0;
      int_r     <= 1'b0;
      conf_r    <= 1'b0;
      width_r   <= '0;
      height_r  <= '0;
    end else begin
      phase_r   <= phase_nxt;
      bif_r     <= bif_nxt;
      pix_cnt_r <= pix_cnt_nxt;
      acc_r     <= acc_nxt;
      hdr_len_r <= hdr_len_nxt;
      size_r    <= size_nxt;
      fnum_r    <= fnum_nxt;
      total_r   <= PIX_W'(prod);
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DEPTH_PRESENT: dmap_r   <= cfg_data[0];
          REG_IMAGE_WIDTH:   width_r  <= cfg_data[IMG_W-1:0];
          REG_IMAGE_HEIGHT:  height_r <= cfg_data[IMG_W-1:0];
          REG_DIST_PRESENT:  dist_r   <= cfg_data[0];
          REG_INT_PRESENT:   int_r    <= cfg_data[0];
          REG_CONF_PRESENT:  conf_r   <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Output buffer
  dfd_result_t out_data;

  dfd_out_skid u_out_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_acc && res_vld),
    .push_ready (res_ready),
    .push_data  (res),
    .pop_valid  (out_bus.valid),
    .pop_ready  (out_bus.ready),
    .pop_data   (out_data)
  );

  assign out_bus.item_kind   = out_data.kind;
  assign out_bus.item_value  = out_data.value;
  assign out_bus.pixel_index = out_data.index;
  assign out_bus.error_code  = out_data.err;
endmodule

// ===== rtl/dfd_out_skid.sv =====
module dfd_out_skid (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  dfd_pkg::dfd_result_t push_data,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output dfd_pkg::dfd_result_t pop_data
);
  import dfd_pkg::*;

  logic        out_vld_r;
  logic        skid_vld_r;
  dfd_result_t out_r;
  dfd_result_t skid_r;
  logic        push_acc;

  assign push_ready = !skid_vld_r;
  assign push_acc   = push_valid && push_ready;
  assign pop_valid  = out_vld_r;
  assign pop_data   = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (!out_vld_r || pop_ready) begin
        if (skid_vld_r) begin
          out_r      <= skid_r;
          out_vld_r  <= 1'b1;
          skid_vld_r <= 1'b0;
        end else begin
          out_r     <= push_data;
          out_vld_r <= push_acc;
        end
      end else if (push_acc) begin
        // output stalled: park the new beat
        skid_r     <= push_data;
        skid_vld_r <= 1'b1;
      end
    end
  end
endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dfd_pkg::*;

  // Parser position, mirrors the field order of one frame
  typedef enum logic [3:0] {
    PH_LEN, PH_TS, PH_VER, PH_FNUM, PH_SKIP,
    PH_DIST, PH_INT, PH_CONF, PH_CRC, PH_LCOPY
  } parse_phase_t;

  // One byte of the data set as offered on in_bus
  typedef struct {
    logic [DATA_W-1:0] b;
    logic [SIZE_W-1:0] sz;
    bit                hold;   // wait for all parsed fields to drain first
  } stream_byte_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  dfd_in_if  in_bus();
  dfd_out_if out_bus();

  depth_frame_deframer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Register shadow, written together with the port
  // ---------------------------------------------------------------------------
  bit              cfg_depth, cfg_dist, cfg_int, cfg_conf;
  logic [IMG_W-1:0] cfg_w, cfg_h;

  // Parser shadow state
  parse_phase_t      ph = PH_LEN;
  int                bif = 0;          // byte within current field
  int                pix = 0;          // pixel within current map
  logic [63:0]       acc = '0;
  logic [31:0]       hdr_len = '0;
  logic [FNUM_W-1:0] fnum_kept = '0;
  logic [31:0]       size_latch = '0;

  dfd_result_t  parsed_q[$];   // fields still to come out of the block
  stream_byte_t byte_q[$];     // bytes not yet offered

  int n_pushed = 0, n_taken = 0, n_dropped = 0;
  int n_seen = 0, n_errs = 0, n_cfg = 0;
  int n_kind[8];

  // ---------------------------------------------------------------------------
  // Field prediction
  // ---------------------------------------------------------------------------
  function automatic int pixel_total();
    int w, h;
    w = (cfg_w > MAX_WIDTH_DEF)  ? MAX_WIDTH_DEF  : int'(cfg_w);
    h = (cfg_h > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(cfg_h);
    return w * h;
  endfunction

  // first present map at or after 'from'; straight to the CRC on an empty image
  function automatic parse_phase_t first_map_from(parse_phase_t from);
    if (pixel_total() == 0) return PH_CRC;
    if (from <= PH_DIST && cfg_dist) return PH_DIST;
    if (from <= PH_INT && cfg_int) return PH_INT;
    if (from <= PH_CONF && cfg_conf) return PH_CONF;
    return PH_CRC;
  endfunction

  function automatic void add_field(dfd_kind_t k, logic [VALUE_W-1:0] v,
                                    logic [INDEX_W-1:0] idx, dfd_err_t e);
    dfd_result_t r;
    r.kind  = k;
    r.value = v;
    r.index = idx;
    r.err   = e;
    parsed_q.push_back(r);
  endfunction

  function automatic void parse_byte(logic [DATA_W-1:0] b, logic [SIZE_W-1:0] psize);
    logic [63:0]  v;
    int           need;
    parse_phase_t here;
    if (!cfg_depth) begin
      n_dropped++;   // block swallows the byte, position held
      return;
    end
    if (ph == PH_LEN && bif == 0) size_latch = psize;
    acc = acc | (64'(b) << (8 * bif));
    bif++;
    case (ph)
      PH_TS: need = 8;
      PH_VER, PH_SKIP, PH_DIST, PH_INT, PH_CONF: need = 2;
      default: need = 4;
    endcase
    if (bif < need) return;
    v   = acc;
    acc = '0;
    bif = 0;
    case (ph)
      PH_LEN: begin
        hdr_len = v[31:0];
        if (hdr_len > size_latch) begin
          ph = PH_LEN;
          add_field(KIND_ERR, 64'(hdr_len), '0, ERR_LEN_SIZE);
        end else begin
          ph = PH_TS;
        end
      end
      PH_TS: begin
        ph = PH_VER;
        add_field(KIND_TS, v, '0, ERR_NONE);
      end
      PH_VER: begin
        if (v[15:0] > 16'd1) begin
          ph = PH_FNUM;
        end else begin
          // old format: no frame number in the stream, count locally
          fnum_kept = fnum_kept + 1'b1;
          pix = 0;
          ph = first_map_from(PH_DIST);
          add_field(KIND_FNUM, 64'(fnum_kept), '0, ERR_NONE);
        end
      end
      PH_FNUM: begin
        fnum_kept = v[31:0];
        ph = PH_SKIP;
        add_field(KIND_FNUM, 64'(fnum_kept), '0, ERR_NONE);
      end
      PH_SKIP: begin
        pix = 0;
        ph = first_map_from(PH_DIST);
      end
      PH_DIST, PH_INT, PH_CONF: begin
        here = ph;
        add_field(here == PH_DIST ? KIND_DIST : here == PH_INT ? KIND_INT : KIND_CONF,
                  64'(v[15:0]), INDEX_W'(pix), ERR_NONE);
        pix++;
        // live pixel total: a shrunk image ends the map on the next pixel
        if (pix >= pixel_total()) begin
          pix = 0;
          ph = first_map_from(parse_phase_t'(here + 1));
        end
      end
      PH_CRC: ph = PH_LCOPY;
      default: begin
        ph = PH_LEN;
        if (v[31:0] != hdr_len) add_field(KIND_ERR, 64'(v[31:0]), '0, ERR_LEN_COPY);
        else add_field(KIND_OK, 64'(fnum_kept), '0, ERR_NONE);
      end
    endcase
  endfunction

  // mostly back to back, sometimes a short gap, now and then a long gap
  function automatic int idle_len(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // ---------------------------------------------------------------------------
  // Byte driver
  // ---------------------------------------------------------------------------
  int in_gap;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid        <= 1'b0;
      in_bus.data_byte    <= '0;
      in_bus.package_size <= '0;
      in_gap = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        parse_byte(in_bus.data_byte, in_bus.package_size);
        n_taken++;
        in_gap = idle_len((n_taken / 150) % 5 == 4);
      end
      // free to change the offer only when nothing is held
      if (!in_bus.valid || in_bus.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_bus.valid <= 1'b0;
        end else if (byte_q.size() > 0 && !(byte_q[0].hold && parsed_q.size() > 0)) begin
          in_bus.valid        <= 1'b1;
          in_bus.data_byte    <= byte_q[0].b;
          in_bus.package_size <= byte_q[0].sz;
          void'(byte_q.pop_front());
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor
  // ---------------------------------------------------------------------------
  int out_stall, hold_left;

  function automatic void note_error(string msg);
    if (n_errs < 10) $display("tb: mismatch at %0t ns: %s", $time, msg);
    n_errs++;
  endfunction

  function automatic void check_beat();
    dfd_result_t want;
    if (parsed_q.size() == 0) begin
      note_error($sformatf("beat with nothing expected: kind %0d value %h index %0d err %0d",
                           out_bus.item_kind, out_bus.item_value, out_bus.pixel_index,
                           out_bus.error_code));
      return;
    end
    want = parsed_q.pop_front();
    if (out_bus.item_kind !== want.kind || out_bus.item_value !== want.value ||
        out_bus.pixel_index !== want.index || out_bus.error_code !== want.err)
      note_error($sformatf("want kind %0d value %h index %0d err %0d, got %0d %h %0d %0d",
                           want.kind, want.value, want.index, want.err, out_bus.item_kind,
                           out_bus.item_value, out_bus.pixel_index, out_bus.error_code));
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      out_stall = 0;
      hold_left = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        check_beat();
        n_kind[out_bus.item_kind]++;
        n_seen++;
        // long back-pressure: output buffer fills, input must stall
        if (n_seen == 100 || n_seen == 2000) hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (out_stall > 0) begin
        out_stall--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
        out_stall = idle_len((n_seen / 120) % 4 == 1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_byte(logic [DATA_W-1:0] b, logic [SIZE_W-1:0] sz, bit hold);
    stream_byte_t s;
    s.b    = b;
    s.sz   = sz;
    s.hold = hold;
    byte_q.push_back(s);
    n_pushed++;
  endtask

  // all bytes taken, all fields out, then a pause for any trailing work
  task automatic wait_quiet();
    while (n_taken != n_pushed || parsed_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(dfd_reg_t r, int val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    case (r)
      REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT: cfg_data <= val[CFG_DAT_W-1:0];
      // junk in the unused upper bits of the one-bit registers
      default: cfg_data <= {9'($urandom), val[0]};
    endcase
    case (r)
      REG_DEPTH_PRESENT: cfg_depth = val[0];
      REG_IMAGE_WIDTH:   cfg_w     = val[IMG_W-1:0];
      REG_IMAGE_HEIGHT:  cfg_h     = val[IMG_W-1:0];
      REG_DIST_PRESENT:  cfg_dist  = val[0];
      REG_INT_PRESENT:   cfg_int   = val[0];
      default:           cfg_conf  = val[0];
    endcase
  endtask

  task automatic set_config(bit dm, int w, int h, bit dd, bit di, bit dc);
    write_reg(REG_DEPTH_PRESENT, dm);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_DIST_PRESENT, dd);
    write_reg(REG_INT_PRESENT, di);
    write_reg(REG_CONF_PRESENT, dc);
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (3) @(posedge clk);   // short pause before the next bytes
    n_cfg++;
  endtask

  // One frame laid out for the current image setup; cut < 0 sends it all
  task automatic queue_frame(logic [31:0] len, logic [31:0] psize, logic [63:0] ts,
                             logic [15:0] ver, logic [31:0] fnum, logic [31:0] copy,
                             bit hold, int cut);
    logic [7:0] fb[$];
    int npix, nmaps;
    npix  = pixel_total();
    nmaps = int'(cfg_dist) + int'(cfg_int) + int'(cfg_conf);
    for (int i = 0; i < 4; i++) fb.push_back(len[8*i +: 8]);
    if (len <= psize) begin
      for (int i = 0; i < 8; i++) fb.push_back(ts[8*i +: 8]);
      for (int i = 0; i < 2; i++) fb.push_back(ver[8*i +: 8]);
      if (ver > 16'd1) begin
        for (int i = 0; i < 4; i++) fb.push_back(fnum[8*i +: 8]);
        repeat (2) fb.push_back(8'($urandom));
      end
      if (npix > 0) repeat (2 * npix * nmaps) fb.push_back(8'($urandom));
      repeat (4) fb.push_back(8'($urandom));   // CRC, not checked by the block
      for (int i = 0; i < 4; i++) fb.push_back(copy[8*i +: 8]);
    end
    if (cut < 0 || cut > fb.size()) cut = fb.size();
    for (int i = 0; i < cut; i++)
      push_byte(fb[i], (i == 0) ? psize : 32'($urandom), hold && i == 0);
  endtask

  task automatic queue_random_frame();
    logic [31:0] len, psize, copy, fnum;
    logic [63:0] ts;
    logic [15:0] ver;
    int r;
    ts = {32'($urandom), 32'($urandom)};
    case ($urandom_range(3))
      0: ver = 16'd0;
      1: ver = 16'd1;
      2: ver = 16'd2;
      default: ver = 16'($urandom);
    endcase
    fnum = $urandom_range(1) ? 32'($urandom) : 32'hFFFF_FFFF - $urandom_range(2);
    len  = $urandom_range(3) == 0 ? 32'($urandom_range(64)) : 32'($urandom);
    r = $urandom_range(99);
    if (r < 10) begin
      if (len == 0) len = 1;
      psize = $urandom_range(len - 1, 0);
    end else begin
      psize = $urandom_range(1) ? len : (len | 32'($urandom));
    end
    copy = (r >= 10 && r < 20) ? len ^ (32'd1 << $urandom_range(31)) : len;
    queue_frame(len, psize, ts, ver, fnum, copy, $urandom_range(29) == 0, -1);
  endtask

  // after a broken frame: feed single bytes until the parser is back at a length
  task automatic resync();
    while (ph != PH_LEN || bif != 0) begin
      push_byte(8'($urandom), 32'($urandom), 1'b0);
      while (n_taken != n_pushed) @(posedge clk);
    end
  endtask

  initial begin
    int rand_bytes, start, w, h;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_bus.valid = 1'b0;
    in_bus.data_byte    = '0;
    in_bus.package_size = '0;
    out_bus.ready       = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // out of reset the depth map is off: every byte is dropped
    repeat (6) push_byte(8'($urandom), 32'($urandom), 1'b0);
    wait_quiet();

    // empty image: header, frame number, length check only
    set_config(1, 0, 0, 0, 0, 0);
    queue_frame(32'd0, 32'd0, 64'd0, 16'd0, 32'd0, 32'd0, 0, -1);
    queue_frame('1, '1, '1, 16'd1, 32'd0, '1, 0, -1);
    queue_frame(32'd100, 32'd200, 64'h0123_4567_89AB_CDEF, 16'd2, 32'hFFFF_FFFF,
                32'd100, 0, -1);
    // local counter wraps from all ones; sender pauses until the block drains
    queue_frame(32'd7, 32'd7, 64'hFEDC_BA98_7654_3210, 16'd0, 32'd0, 32'd7, 1, -1);
    // length one above package size
    queue_frame(32'd9, 32'd8, 64'd5, 16'd0, 32'd0, 32'd9, 0, -1);
    // trailing length copy differs
    queue_frame(32'd20, 32'd30, 64'd6, 16'hFFFF, 32'h8000_0001, 32'd21, 0, -1);
    wait_quiet();

    // small image with all three maps, both header formats
    set_config(1, 3, 2, 1, 1, 1);
    queue_frame(32'd40, 32'd40, 64'd11, 16'd1, 32'd0, 32'd40, 0, -1);
    queue_frame(32'd41, 32'd90, 64'd12, 16'd5, 32'd77, 32'd41, 0, -1);
    wait_quiet();

    // config change inside a frame: stop after ten distance pixels
    set_config(1, 4, 4, 1, 0, 1);
    queue_frame(32'd50, 32'd60, 64'd13, 16'd0, 32'd0, 32'd50, 0, 4 + 8 + 2 + 20);
    wait_quiet();
    set_config(1, 2, 4, 1, 0, 1);   // total drops below the count already seen
    set_config(0, 2, 4, 1, 0, 1);   // depth map off mid-frame: position held
    repeat (5) push_byte(8'($urandom), 32'($urandom), 1'b0);
    wait_quiet();
    set_config(1, 2, 4, 1, 0, 1);
    resync();
    wait_quiet();

    // extreme image sizes
    set_config(1, 1023, 0, 1, 1, 1);   // maps on but no rows: nothing to read
    queue_frame(32'd3000, 32'd5000, 64'd21, 16'd3, 32'd500, 32'd3000, 0, -1);
    wait_quiet();
    set_config(1, 260, 1, 0, 0, 1);    // one long row, index past eight bits
    queue_frame(32'd3001, 32'd3001, 64'd22, 16'd0, 32'd0, 32'd3001, 0, -1);
    wait_quiet();
    set_config(1, 1023, 1023, 0, 0, 0);   // no map carried: nothing to read
    queue_frame(32'd24, 32'd24, 64'd23, 16'd0, 32'd0, 32'd24, 0, -1);
    queue_frame(32'd25, 32'd30, 64'd24, 16'd2, 32'd9, 32'd25, 0, -1);

    // random phases: mostly small images, well-formed frames, some damage
    rand_bytes = 0;
    while (rand_bytes < 350) begin
      wait_quiet();
      w = $urandom_range(9) == 0 ? 0 : $urandom_range(6, 1);
      h = $urandom_range(9) == 0 ? 0 : $urandom_range(4, 1);
      set_config($urandom_range(11) != 0, w, h, $urandom_range(1), $urandom_range(1),
                 $urandom_range(1));
      start = n_pushed;
      repeat ($urandom_range(8, 2)) queue_random_frame();
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(12, 1)) push_byte(8'($urandom), 32'($urandom), 1'b0);
      if (cfg_depth) begin
        wait_quiet();
        resync();
        rand_bytes += n_pushed - start;
      end
    end

    wait_quiet();
    repeat (20) @(posedge clk);
    $display("tb: %0d bytes taken (%0d dropped with depth map off), %0d settings",
             n_taken, n_dropped, n_cfg);
    $display("tb: %0d beats checked: %0d pixels, %0d frames ok, %0d flagged frames",
             n_seen, n_kind[KIND_DIST] + n_kind[KIND_INT] + n_kind[KIND_CONF],
             n_kind[KIND_OK], n_kind[KIND_ERR]);
    if (n_errs == 0 && parsed_q.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // watchdog, far above the slowest legal run
  initial begin
    #5ms;
    $display("tb: timeout, %0d fields still expected", parsed_q.size());
    $display("tb: done, errors");
    $finish;
  end

endmodule
